@@ src/mwss_pkg.sv @@
// mwss_pkg: sizes, codes and helper functions for the maximum window sum search core
// no dependencies; imported by max_window_sum_search_core
`default_nettype none

package mwss_pkg;

  // ring depth and the sample width kept in it
  localparam int MAX_WINDOW  = 256;
  localparam int SAMPLE_BITS = 16;

  // field widths fixed by the interface
  localparam int SAMPLE_FIELD_BITS = 16;
  localparam int LEN_BITS          = 9;
  localparam int CNT_BITS          = 24;
  localparam int OUT_SUM_BITS      = 24;
  localparam int M_TDATA_BITS      = 48;

  // derived sizes
  localparam int PTR_BITS = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int ACC_BITS = SAMPLE_BITS + PTR_BITS + 1;
  localparam int ADDR_EXT_BITS = ((LEN_BITS > PTR_BITS) ? LEN_BITS : PTR_BITS) + 1;

  localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};

  typedef logic [LEN_BITS-1:0]        len_t;
  typedef logic [PTR_BITS-1:0]        ptr_t;
  typedef logic [CNT_BITS-1:0]        cnt_t;
  typedef logic signed [ACC_BITS-1:0] acc_t;
  typedef logic [SAMPLE_BITS-1:0]     smp_t;

  // clamp the written length into 1..MAX_WINDOW
  function automatic len_t eff_len(input len_t raw);
    len_t res;
    res = raw;
    if (raw == '0) begin
      res = len_t'(1);
    end else if (int'(raw) > MAX_WINDOW) begin
      res = len_t'(MAX_WINDOW);
    end
    return res;
  endfunction

  // sign-extend a ring sample to accumulator width
  function automatic acc_t ext_sample(input smp_t raw);
    return acc_t'(signed'(raw));
  endfunction

  // saturate an exact sum to the output sum range
  function automatic logic [OUT_SUM_BITS-1:0] sat_sum(input acc_t v);
    acc_t hi;
    acc_t lo;
    logic [OUT_SUM_BITS-1:0] res;
    hi = acc_t'({1'b0, {(OUT_SUM_BITS-1){1'b1}}});
    lo = -hi - acc_t'(1);
    if (v > hi) begin
      res = {1'b0, {(OUT_SUM_BITS-1){1'b1}}};
    end else if (v < lo) begin
      res = {1'b1, {(OUT_SUM_BITS-1){1'b0}}};
    end else begin
      res = v[OUT_SUM_BITS-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ src/max_window_sum_search_core.sv @@
// max_window_sum_search_core: streaming search for the best fixed-length window sum
// depends on mwss_pkg (sizes, length clamp, sign extension, output saturation)
`default_nettype none

// Takes a stream of signed samples on the slave side and tracks the sum of the
// last window_length samples. The first full window sets the best sum; every
// later window with an equal or larger sum replaces it, so the latest best
// window wins. On the item marked with tlast one result leaves on the master
// side with the start index and the sum of that best window, and the stream
// state is cleared for the next run. A run shorter than window_length gives a
// result with too_short set and zero data. Throughput is one item per clock:
// the running-sum update (one add, one subtract, one compare) is
// combinational, and the outgoing sample comes from a 256-entry ring memory
// whose single read port is addressed one item ahead, so its registered data
// is ready when the item arrives. The input stalls only while a result waits
// in the output register and the master side does not take it. The result
// is registered and appears in the cycle after the tlast item. The ring has
// no reset and no clearing pass; entries are read only after being written
// in the current run. Writing window_length (0 reads as 1, above 256 as 256)
// also restarts the run. The user must write it only while idle; not enforced.
module max_window_sum_search_core
  import mwss_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  // configuration: window_length
  input  wire logic                    cfg_we,
  input  wire logic [LEN_BITS-1:0]     cfg_wdata,
  // input items
  input  wire logic                    s_tvalid,
  output logic                         s_tready,
  input  wire logic [SAMPLE_FIELD_BITS-1:0] s_tdata,   // [15:0] sample
  input  wire logic                    s_tlast,         // last sample of the run
  // result items
  output logic                         m_tvalid,
  input  wire logic                    m_tready,
  output logic [M_TDATA_BITS-1:0]      m_tdata,   // [23:0] best_start, [47:24] best_sum
  output logic                         m_tuser    // [0] too_short
);

  // configuration and stream state
  len_t win_len;
  ptr_t wp;
  ptr_t wp_next;
  acc_t running_sum;
  acc_t running_sum_next;
  acc_t best_total;
  acc_t best_total_next;
  cnt_t best_position;
  cnt_t best_position_next;
  cnt_t item_count;
  cnt_t item_count_next;

  // ring memory and its prefetched read
  smp_t ring [MAX_WINDOW];
  smp_t rd_data;
  smp_t fwd_sample;
  logic fwd;
  ptr_t rd_addr;

  logic accept;
  acc_t s_ext;
  acc_t old_ext;
  acc_t sum_new;
  acc_t best_upd;
  cnt_t pos_upd;
  cnt_t cnt_inc;
  cnt_t len_cnt;
  logic filling;
  logic too_short;

  logic [ADDR_EXT_BITS-1:0] ext_wp;
  logic [ADDR_EXT_BITS-1:0] ext_len;
  logic [ADDR_EXT_BITS-1:0] ext_diff;

  // a new item is taken whenever the result register is free or being drained
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign s_ext   = ext_sample(s_tdata[SAMPLE_BITS-1:0]);
  // sample leaving the window; forwarded when it was written on the last edge
  assign old_ext = ext_sample(fwd ? fwd_sample : rd_data);
  assign len_cnt = cnt_t'(win_len);
  assign filling = item_count < len_cnt;
  assign cnt_inc = (item_count == CNT_MAX) ? item_count : item_count + cnt_t'(1);
  assign too_short = cnt_inc < len_cnt;

  // window sum and best tracking for the item at the input
  always_comb begin
    best_upd = best_total;
    pos_upd  = best_position;
    if (filling) begin
      sum_new = running_sum + s_ext;
      // first full window sets the best
      if (cnt_t'(item_count + cnt_t'(1)) == len_cnt) begin
        best_upd = sum_new;
        pos_upd  = '0;
      end
    end else begin
      sum_new = running_sum - old_ext + s_ext;
      // ties move the best window forward
      if (sum_new >= best_total) begin
        best_upd = sum_new;
        pos_upd  = item_count - len_cnt + cnt_t'(1);
      end
    end
  end

  // next stream state: a config write or the end of a run clears it
  always_comb begin
    wp_next            = wp;
    running_sum_next   = running_sum;
    best_total_next    = best_total;
    best_position_next = best_position;
    item_count_next    = item_count;
    if (cfg_we) begin
      wp_next            = '0;
      running_sum_next   = '0;
      best_total_next    = '0;
      best_position_next = '0;
      item_count_next    = '0;
    end else if (accept) begin
      if (s_tlast) begin
        wp_next            = '0;
        running_sum_next   = '0;
        best_total_next    = '0;
        best_position_next = '0;
        item_count_next    = '0;
      end else begin
        wp_next            = (wp == ptr_t'(MAX_WINDOW - 1)) ? '0 : wp + ptr_t'(1);
        running_sum_next   = sum_new;
        best_total_next    = best_upd;
        best_position_next = pos_upd;
        item_count_next    = cnt_inc;
      end
    end
  end

  // prefetch address: slot of the sample that leaves when the next item comes
  always_comb begin
    ext_wp  = ADDR_EXT_BITS'(wp_next);
    ext_len = ADDR_EXT_BITS'(win_len);
    if (ext_wp >= ext_len) begin
      ext_diff = ext_wp - ext_len;
    end else begin
      ext_diff = ext_wp + ADDR_EXT_BITS'(MAX_WINDOW) - ext_len;
    end
    rd_addr = ext_diff[PTR_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ring[wp] <= s_tdata[SAMPLE_BITS-1:0];
    end
    rd_data    <= ring[rd_addr];
    fwd_sample <= s_tdata[SAMPLE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_len       <= len_t'(1);
      wp            <= '0;
      running_sum   <= '0;
      best_total    <= '0;
      best_position <= '0;
      item_count    <= '0;
      fwd           <= 1'b0;
    end else begin
      if (cfg_we) begin
        win_len <= eff_len(cfg_wdata);
      end
      wp            <= wp_next;
      running_sum   <= running_sum_next;
      best_total    <= best_total_next;
      best_position <= best_position_next;
      item_count    <= item_count_next;
      // read and write hit the same slot: take the new sample instead
      fwd           <= accept && (rd_addr == wp);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept && s_tlast) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && s_tlast) begin
      if (too_short) begin
        m_tdata <= '0;
        m_tuser <= 1'b1;
      end else begin
        m_tdata <= {sat_sum(best_upd), pos_upd};
        m_tuser <= 1'b0;
      end
    end
  end

  // a short run reports zero data
  a_short_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("too_short result with nonzero data");

  // the end of a run leaves a cleared stream
  a_run_clear: assert property (@(posedge clk) disable iff (rst)
    accept && s_tlast |=> item_count == '0 && wp == '0 && running_sum == '0)
    else $error("stream state not cleared after last item");

  // every last item yields a result on the next cycle
  a_result_out: assert property (@(posedge clk) disable iff (rst)
    accept && s_tlast |=> m_tvalid)
    else $error("last item gave no result");

  // the item counter advances on each accepted non-last item without a config write, until it saturates
  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    accept && !s_tlast && !cfg_we && item_count != CNT_MAX |=>
      item_count == $past(item_count) + cnt_t'(1))
    else $error("item counter did not advance");

endmodule

`default_nettype wire
